[sv/pnmhp_pkg.sv]
// Package for the PNM header parser: character codes, status codes and
// the result record passed from the parse core to the top level.
// No dependencies.
package pnmhp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_1     = 8'h31;
  localparam logic [7:0] CHAR_6     = 8'h36;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAGIC    = 3'd1;
  localparam logic [2:0] ST_DIGIT    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;
  localparam logic [2:0] ST_EARLY    = 3'd5;

  // Format digits for bitmap types (maxval not read) and the last plain-text format
  localparam logic [2:0] FMT_PBM_PLAIN = 3'd1;
  localparam logic [2:0] FMT_PBM_RAW   = 3'd4;
  localparam logic [2:0] FMT_LAST_TEXT = 3'd3;

  // Largest maxval
  localparam logic [15:0] MAX_SAMPLE_LIMIT = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  format_number;
    logic        plain_text;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [15:0] max_sample;
    logic [1:0]  sample_bytes;
  } result_t;

endpackage

[sv/pnm_header_parser_unit.sv]
// PNM header parser top level: input register, parse core and result
// register with valid/stall handshake on both channels.
// Depends on pnmhp_pkg and pnmhp_core.
//
// Usage:
//   The input channel carries one file byte per transaction together with
//   first_byte (restart the parse on this byte) and end_of_stream (no byte,
//   the file has ended). The output channel carries one result transaction
//   when a header completes or fails; bytes that cause no result produce no
//   output transaction, and bytes outside a header are ignored.
//   A result passes the input register, which loads on the transaction of
//   the byte that caused it, and then the result register, which loads
//   when the core steps on that byte.
//   Throughput: one byte per cycle while no held result is stalled. The
//   multiply-by-ten accumulate and the phase update form a loop through the
//   parse state registers, so each byte is processed in a single step.
//   When the receiver stalls while a result is held, the core stops and the
//   input register holds its byte; in_stall_o rises until the result is
//   taken.
//   Reset clears the parse phase to idle (waiting for a first byte) and
//   empties the input and result registers.
module pnm_header_parser_unit import pnmhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        first_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  format_number_o,
  output logic        plain_text_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o,
  output logic [15:0] max_sample_o,
  output logic [1:0]  sample_bytes_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  logic        first_q;
  logic        eos_q;
  logic        out_valid_q, out_valid_d;
  result_t     res_q;
  logic        step;
  logic        in_accept;
  logic        res_valid;
  result_t     res;

  // Core steps when the result register can take whatever it produces
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !step);
  assign out_valid_d = (step && res_valid) || (out_valid_q && out_stall_i);

  pnmhp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .byte_value_i   (byte_q),
    .first_byte_i   (first_q),
    .end_of_stream_i(eos_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= byte_value_i;
      first_q <= first_byte_i;
      eos_q   <= end_of_stream_i;
    end
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign format_number_o = res_q.format_number;
  assign plain_text_o    = res_q.plain_text;
  assign image_width_o   = res_q.image_width;
  assign image_height_o  = res_q.image_height;
  assign max_sample_o    = res_q.max_sample;
  assign sample_bytes_o  = res_q.sample_bytes;

endmodule

[sv/pnmhp_core.sv]
// Parse core of the PNM header parser: phase state machine, comment
// tracking and decimal accumulator. Processes one byte per step.
// Depends on pnmhp_pkg.
module pnmhp_core import pnmhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_value_i,
  input  logic        first_byte_i,
  input  logic        end_of_stream_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  // Phase codes
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_MAGIC_P = 4'd1;
  localparam logic [3:0] PH_MAGIC_D = 4'd2;
  localparam logic [3:0] PH_W_SKIP  = 4'd3;
  localparam logic [3:0] PH_W_NUM   = 4'd4;
  localparam logic [3:0] PH_H_SKIP  = 4'd5;
  localparam logic [3:0] PH_H_NUM   = 4'd6;
  localparam logic [3:0] PH_M_SKIP  = 4'd7;
  localparam logic [3:0] PH_M_NUM   = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic        comment_q, comment_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  fmt_q, fmt_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;

  logic [3:0]  phase_eff;
  logic        comment_eff;
  logic [2:0]  fmt_eff;
  logic        is_ws, is_digit, is_magic;
  logic [31:0] acc_base;
  logic [3:0]  num_phase;
  logic [35:0] acc_next;
  logic        over_limit;
  logic        num_go;

  // A first byte restarts the parse at the magic
  assign phase_eff   = first_byte_i ? PH_MAGIC_P : phase_q;
  assign comment_eff = first_byte_i ? 1'b0 : comment_q;
  assign fmt_eff     = first_byte_i ? 3'd0 : fmt_q;

  // Byte classes
  assign is_ws    = (byte_value_i == CHAR_SPACE) ||
                    ((byte_value_i >= CHAR_TAB) && (byte_value_i <= CHAR_CR));
  assign is_digit = (byte_value_i >= CHAR_0) && (byte_value_i <= CHAR_9);
  assign is_magic = (byte_value_i >= CHAR_1) && (byte_value_i <= CHAR_6);

  // Number base: a skip phase starts a fresh number
  always_comb begin
    acc_base  = acc_q;
    num_phase = phase_eff;
    if ((phase_eff == PH_W_SKIP) || (phase_eff == PH_H_SKIP) ||
        (phase_eff == PH_M_SKIP)) begin
      acc_base  = '0;
      num_phase = phase_eff + 4'd1;
    end
  end

  // acc * 10 + digit, exact overflow check against the field limit
  assign acc_next = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) +
                    {32'b0, byte_value_i[3:0] - CHAR_0[3:0]};
  assign over_limit = (num_phase == PH_M_NUM) ? (acc_next[35:16] != '0)
                                              : (acc_next[35:32] != '0);

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    comment_d   = comment_q;
    acc_d       = acc_q;
    fmt_d       = fmt_q;
    width_d     = width_q;
    height_d    = height_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    num_go      = 1'b0;

    if (step_i) begin
      phase_d   = phase_eff;
      comment_d = comment_eff;
      fmt_d     = fmt_eff;
      if (first_byte_i) begin
        acc_d    = '0;
        width_d  = '0;
        height_d = '0;
      end

      if ((phase_eff == PH_IDLE) || (phase_eff > PH_M_NUM)) begin
        // idle: byte ignored
      end else if (end_of_stream_i) begin
        res_valid_o  = 1'b1;
        res_o.status = ST_EARLY;
        phase_d      = PH_IDLE;
      end else if (byte_value_i == CHAR_HASH) begin
        comment_d = 1'b1;
      end else if (comment_eff) begin
        if ((byte_value_i == CHAR_LF) || (byte_value_i == CHAR_CR)) begin
          comment_d = 1'b0;
        end
      end else begin
        unique case (phase_eff)
          PH_MAGIC_P: begin
            if (byte_value_i != CHAR_P) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_MAGIC;
              phase_d      = PH_IDLE;
            end else begin
              phase_d = PH_MAGIC_D;
            end
          end
          PH_MAGIC_D: begin
            if (!is_magic) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_MAGIC;
              phase_d      = PH_IDLE;
            end else begin
              fmt_d   = byte_value_i[2:0];
              phase_d = PH_W_SKIP;
            end
          end
          PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: begin
            num_go = !is_ws;
          end
          default: begin
            num_go = 1'b1;
          end
        endcase

        if (num_go) begin
          if (is_ws) begin
            if (acc_base == '0) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_ZERO;
              phase_d      = PH_IDLE;
            end else if (num_phase == PH_W_NUM) begin
              width_d = acc_base;
              phase_d = PH_H_SKIP;
            end else if ((num_phase == PH_H_NUM) &&
                         (fmt_eff != FMT_PBM_PLAIN) && (fmt_eff != FMT_PBM_RAW)) begin
              height_d = acc_base;
              phase_d  = PH_M_SKIP;
            end else begin
              // header complete
              res_valid_o         = 1'b1;
              res_o.status        = ST_OK;
              res_o.format_number = fmt_eff;
              res_o.plain_text    = (fmt_eff <= FMT_LAST_TEXT);
              res_o.image_width   = width_q;
              res_o.image_height  = (num_phase == PH_H_NUM) ? acc_base : height_q;
              res_o.max_sample    = (num_phase == PH_H_NUM) ? 16'd1 : acc_base[15:0];
              res_o.sample_bytes  = (res_o.max_sample[15:8] == '0) ? 2'd1 : 2'd2;
              if (num_phase == PH_H_NUM) begin
                height_d = acc_base;
              end
              phase_d = PH_IDLE;
            end
          end else if (!is_digit) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_DIGIT;
            phase_d      = PH_IDLE;
          end else if (over_limit) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_OVERFLOW;
            phase_d      = PH_IDLE;
          end else begin
            acc_d   = acc_next[31:0];
            phase_d = num_phase;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      comment_q <= 1'b0;
      acc_q     <= '0;
      fmt_q     <= '0;
      width_q   <= '0;
      height_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      comment_q <= comment_d;
      acc_q     <= acc_d;
      fmt_q     <= fmt_d;
      width_q   <= width_d;
      height_q  <= height_d;
    end
  end

endmodule

[sim/pnm_header_parser_unit_tb.sv]
// Testbench for pnm_header_parser_unit: byte streams of PNM headers, well formed and
// broken, go through a byte-level header predictor and each result transaction is checked.
// Depends on pnmhp_pkg and the parser RTL.
module pnm_header_parser_unit_tb import pnmhp_pkg::*; ();

  // Parser phases of the predictor
  typedef enum logic [3:0] {
    PH_IDLE, PH_MAGIC_P, PH_MAGIC_D, PH_W_SKIP, PH_W_NUM,
    PH_H_SKIP, PH_H_NUM, PH_M_SKIP, PH_M_NUM
  } parse_phase_e;

  // One input transaction
  typedef struct packed {
    logic [7:0] byte_val;
    logic       first_flag;
    logic       eos_flag;
  } stim_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  byte_value_i;
  logic        first_byte_i;
  logic        end_of_stream_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [2:0]  format_number_o;
  logic        plain_text_o;
  logic [31:0] image_width_o;
  logic [31:0] image_height_o;
  logic [15:0] max_sample_o;
  logic [1:0]  sample_bytes_o;

  // Predictor state
  parse_phase_e pred_phase;
  logic         pred_in_comment;
  logic [31:0]  pred_acc;
  logic [2:0]   pred_format;
  logic [31:0]  pred_width;
  logic [31:0]  pred_height;

  // Expected headers and bookkeeping
  result_t expected_headers[$];
  stim_t   file_q[$];
  result_t got_hdr;
  result_t want_hdr;
  int      mismatch_count = 0;
  int      parsed_bytes = 0;
  int      headers_seen = 0;
  int      status_count[8];
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_request = 0;
  int      hold_left = 0;

  pnm_header_parser_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_value_i   (byte_value_i),
    .first_byte_i   (first_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .format_number_o(format_number_o),
    .plain_text_o   (plain_text_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .max_sample_o   (max_sample_o),
    .sample_bytes_o (sample_bytes_o)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Header predictor: advances on one accepted byte, returns 1 when a header result is due
  function automatic logic predict_header(input stim_t item, output result_t hdr,
                                          output logic active);
    logic [35:0] next_val;
    logic [35:0] limit;
    logic [31:0] maxv;
    logic        blank;
    hdr = '0;
    active = 1'b0;
    blank = (item.byte_val == CHAR_SPACE) ||
            (item.byte_val >= CHAR_TAB && item.byte_val <= CHAR_CR);
    if (item.first_flag) begin
      pred_phase = PH_MAGIC_P;
      pred_in_comment = 1'b0;
      pred_acc = '0;
      pred_format = '0;
      pred_width = '0;
      pred_height = '0;
    end
    if (pred_phase == PH_IDLE) return 1'b0;
    active = 1'b1;
    // end of stream fails anywhere in a header
    if (item.eos_flag) begin
      hdr.status = ST_EARLY;
      pred_phase = PH_IDLE;
      return 1'b1;
    end
    // comments vanish before any other parsing
    if (item.byte_val == CHAR_HASH) begin
      pred_in_comment = 1'b1;
      return 1'b0;
    end
    if (pred_in_comment) begin
      if (item.byte_val == CHAR_LF || item.byte_val == CHAR_CR) pred_in_comment = 1'b0;
      return 1'b0;
    end
    case (pred_phase)
      PH_MAGIC_P: begin
        if (item.byte_val != CHAR_P) begin
          hdr.status = ST_MAGIC;
          pred_phase = PH_IDLE;
          return 1'b1;
        end
        pred_phase = PH_MAGIC_D;
        return 1'b0;
      end
      PH_MAGIC_D: begin
        if (item.byte_val < CHAR_1 || item.byte_val > CHAR_6) begin
          hdr.status = ST_MAGIC;
          pred_phase = PH_IDLE;
          return 1'b1;
        end
        pred_format = 3'(item.byte_val - CHAR_0);
        pred_phase = PH_W_SKIP;
        return 1'b0;
      end
      PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: begin
        if (blank) return 1'b0;
        pred_acc = '0;
        pred_phase = parse_phase_e'(pred_phase + 4'd1);
      end
      default: ;
    endcase
    // number byte
    limit = (pred_phase == PH_M_NUM) ? 36'(MAX_SAMPLE_LIMIT) : 36'hFFFFFFFF;
    if (!blank) begin
      if (item.byte_val < CHAR_0 || item.byte_val > CHAR_9) begin
        hdr.status = ST_DIGIT;
        pred_phase = PH_IDLE;
        return 1'b1;
      end
      next_val = 36'(pred_acc) * 36'd10 + 36'(item.byte_val - CHAR_0);
      if (next_val > limit) begin
        hdr.status = ST_OVERFLOW;
        pred_phase = PH_IDLE;
        return 1'b1;
      end
      pred_acc = next_val[31:0];
      return 1'b0;
    end
    if (pred_acc == 0) begin
      hdr.status = ST_ZERO;
      pred_phase = PH_IDLE;
      return 1'b1;
    end
    // number finished
    if (pred_phase == PH_W_NUM) begin
      pred_width = pred_acc;
      pred_phase = PH_H_SKIP;
      return 1'b0;
    end
    maxv = pred_acc;
    if (pred_phase == PH_H_NUM) begin
      pred_height = pred_acc;
      if (pred_format != FMT_PBM_PLAIN && pred_format != FMT_PBM_RAW) begin
        pred_phase = PH_M_SKIP;
        return 1'b0;
      end
      maxv = 32'd1;
    end
    hdr.status = ST_OK;
    hdr.format_number = pred_format;
    hdr.plain_text = (pred_format <= FMT_LAST_TEXT);
    hdr.image_width = pred_width;
    hdr.image_height = pred_height;
    hdr.max_sample = maxv[15:0];
    hdr.sample_bytes = (maxv < 256) ? 2'd1 : 2'd2;
    pred_phase = PH_IDLE;
    return 1'b1;
  endfunction

  // Sends one byte transaction and records the header it completes, if any
  task automatic send_byte(input stim_t item);
    result_t hdr;
    logic    active;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= item.byte_val;
    first_byte_i <= item.first_flag;
    end_of_stream_i <= item.eos_flag;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    if (predict_header(item, hdr, active)) expected_headers.push_back(hdr);
    if (active) parsed_bytes++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends the queued bytes; a new file gets first_byte on its first byte
  task automatic send_queue(input logic new_file);
    if (new_file && file_q.size() != 0) file_q[0].first_flag = 1'b1;
    foreach (file_q[i]) send_byte(file_q[i]);
    file_q.delete();
  endtask

  task automatic wait_drained();
    while (expected_headers.size() != 0) @(posedge clk_i);
  endtask

  // Byte builders
  function automatic void add_byte(input logic [7:0] v);
    file_q.push_back('{byte_val: v, first_flag: 1'b0, eos_flag: 1'b0});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_eos();
    file_q.push_back('{byte_val: 8'($urandom), first_flag: 1'b0, eos_flag: 1'b1});
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CHAR_TAB;
      1: return CHAR_LF;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  // Comment: random body without a line end, closed by CR or LF
  function automatic void add_comment();
    logic [7:0] c;
    add_byte(CHAR_HASH);
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom);
      if (c == CHAR_LF || c == CHAR_CR) c = CHAR_SPACE;
      add_byte(c);
    end
    add_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
  endfunction

  function automatic void add_gap(input int min_len);
    repeat ($urandom_range(min_len, 2)) add_byte(pick_blank());
    if ($urandom_range(0, 6) == 0) add_comment();
  endfunction

  // Decimal digits, sometimes with leading zeros or a comment splitting them
  function automatic void add_number(input logic [39:0] v);
    logic [7:0] digs[$];
    int         cut;
    do begin
      digs.push_front(CHAR_0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 9) == 0) digs.push_front(CHAR_0);
    cut = (digs.size() > 1 && $urandom_range(0, 9) == 0) ?
          $urandom_range(1, digs.size() - 1) : -1;
    foreach (digs[i]) begin
      if (i == cut) add_comment();
      add_byte(digs[i]);
    end
  endfunction

  function automatic logic [39:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 40'hFFFF_FFFF;
      1: return 40'h1_0000_0000;
      2: return 40'd0;
      3, 4: return 40'($urandom);
      5: return 40'd99999999999;
      default: return 40'($urandom_range(1, 1500));
    endcase
  endfunction

  function automatic logic [39:0] pick_maxval();
    case ($urandom_range(0, 19))
      0: return 40'd65535;
      1: return 40'd65536;
      2: return 40'd0;
      3: return 40'd255;
      4: return 40'd256;
      5, 6: return 40'($urandom_range(1, 65535));
      7: return 40'd99999;
      default: return 40'($urandom_range(1, 300));
    endcase
  endfunction

  // Random file: mostly well formed, then sometimes damaged, cut or trailed by noise
  function automatic void build_random_file();
    int         fmt;
    int         r;
    int         keep;
    fmt = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) add_comment();
    add_byte(CHAR_P);
    add_byte(CHAR_0 + 8'(fmt));
    add_gap($urandom_range(0, 5) == 0 ? 0 : 1);
    add_number(pick_dim());
    add_byte(pick_blank());
    add_gap(0);
    add_number(pick_dim());
    add_byte(pick_blank());
    if (fmt != FMT_PBM_PLAIN && fmt != FMT_PBM_RAW) begin
      add_gap(0);
      add_number(pick_maxval());
      add_byte(pick_blank());
    end
    r = $urandom_range(0, 99);
    keep = $urandom_range(1, file_q.size());
    if (r < 2) begin
      file_q.delete();
      add_eos();
    end else if (r < 12) begin
      file_q[$urandom_range(0, file_q.size() - 1)].byte_val = 8'($urandom);
    end else if (r < 22) begin
      while (file_q.size() > keep) void'(file_q.pop_back());
      add_eos();
    end else if (r < 27) begin
      while (file_q.size() > keep) void'(file_q.pop_back());
    end else if (r < 32) begin
      file_q[0].byte_val = 8'($urandom);
    end
    // trailing noise, mostly ignored by an idle parser
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        file_q.push_back('{byte_val: 8'($urandom), first_flag: 1'b0,
                           eos_flag: 1'($urandom_range(0, 3) == 0)});
      end
    end
  endfunction

  task automatic run_random_files(input int target);
    int start;
    start = parsed_bytes;
    while (parsed_bytes - start < target) begin
      build_random_file();
      send_queue(1'b1);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker: values are stable at the falling edge before the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      got_hdr = '{status_o, format_number_o, plain_text_o, image_width_o,
                  image_height_o, max_sample_o, sample_bytes_o};
      headers_seen++;
      if (expected_headers.size() == 0) begin
        $display("%0t: unexpected result transaction, status %0d", $time, status_o);
        mismatch_count++;
      end else begin
        want_hdr = expected_headers.pop_front();
        status_count[want_hdr.status]++;
        check_field("status", 32'(want_hdr.status), 32'(got_hdr.status));
        check_field("format_number", 32'(want_hdr.format_number),
                    32'(got_hdr.format_number));
        check_field("plain_text", 32'(want_hdr.plain_text), 32'(got_hdr.plain_text));
        check_field("image_width", want_hdr.image_width, got_hdr.image_width);
        check_field("image_height", want_hdr.image_height, got_hdr.image_height);
        check_field("max_sample", 32'(want_hdr.max_sample), 32'(got_hdr.max_sample));
        check_field("sample_bytes", 32'(want_hdr.sample_bytes),
                    32'(got_hdr.sample_bytes));
      end
    end
  end

  // Hand-picked headers: every format, extremes and each failure kind
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    add_text("P1 3 2\n");                       send_queue(1'b1);
    add_text("P6640 480 255\n");                send_queue(1'b1);
    add_text("P2 4294967295 7 65535\n");        send_queue(1'b1);
    add_text("P5 1 1 256 ");                    send_queue(1'b1);
    // comment splits the width into 12
    add_text("P3 1#");
    add_byte(8'hA5);
    add_text("z\n2 3 255\t");                   send_queue(1'b1);
    add_text("#hi");
    add_byte(CHAR_CR);
    add_text("P4\t5");
    add_byte(8'h0B);
    add_byte(8'h36);
    add_byte(8'h0C);                            send_queue(1'b1);
    add_text("X");                              send_queue(1'b1);
    add_text("P7");                             send_queue(1'b1);
    add_text("P0");                             send_queue(1'b1);
    add_text("P2 12a");                         send_queue(1'b1);
    add_text("P2 4294967296 ");                 send_queue(1'b1);
    add_text("P5 2 2 65536 ");                  send_queue(1'b1);
    add_text("P2 0 3 ");                        send_queue(1'b1);
    add_text("P3 5 5 00 ");                     send_queue(1'b1);
    add_eos();                                  send_queue(1'b1);
    add_text("P2 #ab");
    add_eos();                                  send_queue(1'b1);
    // restart in the middle of a header, then bytes an idle parser ignores
    add_text("P3 10 ");                         send_queue(1'b1);
    add_text("P1 1 1\n");                       send_queue(1'b1);
    add_text("7 8");
    add_eos();                                  send_queue(1'b0);
    stop_sending();
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0;
    stall_pct = 0;
    run_random_files(350);
    stop_sending();
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 66;
    stall_pct = 0;
    run_random_files(350);
    stop_sending();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 66;
    run_random_files(350);
    stop_sending();
  endtask

  task automatic test_both_idle();
    send_idle_pct = 33;
    stall_pct = 33;
    run_random_files(350);
    stop_sending();
  endtask

  // Long receiver hold-off while bytes keep coming: the input side must back up
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    hold_request = 300;
    @(posedge clk_i);
    run_random_files(250);
    stop_sending();
  endtask

  // Sender waits for every outstanding header between bursts
  task automatic test_drain_pause();
    send_idle_pct = 10;
    stall_pct = 20;
    repeat (4) begin
      run_random_files(60);
      stop_sending();
      wait_drained();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    byte_value_i <= '0;
    first_byte_i <= 1'b0;
    end_of_stream_i <= 1'b0;
    out_stall_i <= 1'b0;
    pred_phase = PH_IDLE;
    pred_in_comment = 1'b0;
    pred_acc = '0;
    pred_format = '0;
    pred_width = '0;
    pred_height = '0;
    foreach (status_count[i]) status_count[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_headers.size() != 0) begin
      $display("%0t: %0d expected headers never arrived", $time, expected_headers.size());
      mismatch_count++;
    end
    $display("Parsed %0d header bytes, checked %0d headers", parsed_bytes, headers_seen);
    $display("By status: ok %0d, magic %0d, digit %0d, overflow %0d, zero %0d, early %0d",
             status_count[ST_OK], status_count[ST_MAGIC], status_count[ST_DIGIT],
             status_count[ST_OVERFLOW], status_count[ST_ZERO], status_count[ST_EARLY]);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d headers outstanding", $time, expected_headers.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
